[hdl/rasz_pkg.sv]
// package for the running average of voice sdu sizes
// holds the field widths and the sequencer state codes
// no dependencies
package rasz_pkg;

  localparam int unsigned SizeW = 16;
  localparam int unsigned StW   = 3;

  localparam logic [StW-1:0] S_IDLE = 3'd0;
  localparam logic [StW-1:0] S_UPD  = 3'd1;
  localparam logic [StW-1:0] S_DIV  = 3'd2;
  localparam logic [StW-1:0] S_DONE = 3'd3;

endpackage

[hdl/running_average_sdu_size_top.sv]
// running average of voice sdu sizes over a ring of WINDOW entries
// depends on rasz_pkg and rasz_ram
//
// channel   direction  handshake               payload
// in        input      in_valid_i / in_stall_o  is_voice_i, sdu_size_i
// out       output     out_valid_o / out_stall_i average_size_o
// cfg       input      cfg_we_i                cfg_wdata_i (average_enable)
//
// a voice item passes through the update, divide and done states, a non-voice item skips update,
// and the divide state runs the bit-serial divider that retires one quotient bit per cycle.
// with averaging disabled an item goes straight to the done state.
// the ring is held in a ram; per-entry valid bits make unwritten entries read as zero.
// a new item is taken while a finished result still waits on out_stall_i.
module running_average_sdu_size_top import rasz_pkg::*; #(
  parameter int unsigned WINDOW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             is_voice_i,
  input  logic [SizeW-1:0] sdu_size_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [SizeW-1:0] average_size_o
);

  localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_W = SizeW + $clog2(WINDOW);
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned IT_W  = $clog2(SUM_W);

  logic [StW-1:0]   st_q, st_d;
  logic             en_q;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [WINDOW-1:0] vld_q, vld_d;
  logic             out_valid_q, out_valid_d;
  logic [SizeW-1:0] out_data_q, out_data_d;

  logic [SizeW-1:0] size_q, size_d;
  logic [IDX_W-1:0] nxt_q, nxt_d;
  logic [SUM_W-1:0] dq_q, dq_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [IT_W-1:0]  it_q, it_d;
  logic             zero_q, zero_d;

  logic             in_acc;
  logic [IDX_W-1:0] nxt_w;
  logic             ram_re, ram_we;
  logic [SizeW-1:0] ram_rdata;
  logic [SizeW-1:0] old_size;
  logic [CNT_W:0]   trial, diff;
  logic             ge;
  logic             out_free;

  assign in_stall_o = (st_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign nxt_w      = (pos_q == IDX_W'(WINDOW - 1)) ? '0 : pos_q + IDX_W'(1);
  assign ram_re     = in_acc && en_q && is_voice_i;
  assign ram_we     = (st_q == S_UPD);
  assign old_size   = vld_q[nxt_q] ? ram_rdata : '0;

  assign trial = {rem_q, dq_q[SUM_W-1]};
  assign ge    = (trial >= {1'b0, cnt_q});
  assign diff  = trial - {1'b0, cnt_q};
  assign out_free = !out_valid_q || !out_stall_i;

  rasz_ram #(
    .Width(SizeW),
    .Depth(WINDOW)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(nxt_q),
    .wdata_i(size_q),
    .re_i   (ram_re),
    .raddr_i(nxt_w),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    st_d        = st_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    vld_d       = vld_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    size_d      = size_q;
    nxt_d       = nxt_q;
    dq_d        = dq_q;
    rem_d       = rem_q;
    it_d        = it_q;
    zero_d      = zero_q;
    unique case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          size_d = sdu_size_i;
          nxt_d  = nxt_w;
          rem_d  = '0;
          it_d   = '0;
          dq_d   = sum_q;
          zero_d = !en_q;
          if (!en_q) begin
            st_d = S_DONE;
          end else if (is_voice_i) begin
            st_d = S_UPD;
          end else begin
            st_d = S_DIV;
          end
        end
      end
      S_UPD: begin
        sum_d = sum_q - SUM_W'(old_size) + SUM_W'(size_q);
        vld_d[nxt_q] = 1'b1;
        pos_d = nxt_q;
        if (cnt_q != CNT_W'(WINDOW)) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
        dq_d = sum_d;
        st_d = S_DIV;
      end
      S_DIV: begin
        rem_d = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        dq_d  = {dq_q[SUM_W-2:0], ge};
        it_d  = it_q + IT_W'(1);
        if (it_q == IT_W'(SUM_W - 1)) begin
          st_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = (zero_q || cnt_q == '0) ? '0 : dq_q[SizeW-1:0];
          st_d        = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      en_q        <= 1'b0;
      pos_q       <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        en_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    size_q     <= size_d;
    nxt_q      <= nxt_d;
    dq_q       <= dq_d;
    rem_q      <= rem_d;
    it_q       <= it_d;
    zero_q     <= zero_d;
  end

  assign out_valid_o    = out_valid_q;
  assign average_size_o = out_data_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(WINDOW))
    else $error("valid count above window");

  a_vld_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld_q) == int'(cnt_q))
    else $error("valid bits disagree with valid count");

  a_empty_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (sum_q == '0))
    else $error("running sum nonzero with empty window");

  a_voice_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && en_q && is_voice_i) |=> (st_q == S_UPD))
    else $error("voice item did not enter update");

  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DIV && it_q == IT_W'(SUM_W - 1)) |=> (st_q == S_DONE))
    else $error("divider did not finish");
`endif

endmodule

[hdl/rasz_ram.sv]
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module rasz_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 8
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
